// File: src/ubds_pkg.sv
// Shared constants and types for the UART baud divisor selector.
// No dependencies; the mode, top-level and testbench files refer to this package by scoped names.
package ubds_pkg;

  localparam int CLK_W   = 32;
  localparam int BAUD_W  = 16;
  localparam int DIV_W   = 12;
  localparam int Q1_W    = 33;  // clock plus rounding half-divisor
  localparam int D1_W    = 20;  // baud times 16
  localparam int D2_W    = 17;  // (divisor + 1) times 16
  localparam int ACH_W   = 30;  // achieved baud never exceeds about clock/8
  localparam int SCALE_W = 17;
  localparam int PROD_W  = 47;  // achieved baud times error scale
  localparam int ADDR_W  = 3;
  localparam int DATA_W  = 32;

  localparam logic [SCALE_W-1:0] ERR_SCALE = SCALE_W'(100000);
  localparam logic [DIV_W-1:0]   DIV_MAX   = DIV_W'(4095);
  localparam logic [Q1_W-1:0]    RAW_MAX   = Q1_W'(4096);

  // Register index of clock_hz in the configuration map
  localparam logic REG_CLOCK_HZ = 1'b0;

  // Register stages from input to output register inclusive
  localparam int LATENCY = Q1_W + 1 + Q1_W + 1 + PROD_W + 1 + 1;

  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_ZERO    = 2'd1,
    STATUS_CLAMPED = 2'd2
  } status_t;

endpackage

// File: src/ubds_div_cell.sv
// One restoring-division cell: produces one quotient bit per cycle while en is high.
// Uses no package items; instantiated by ubds_divider.
module ubds_div_cell #(
  parameter int N = 33,
  parameter int M = 20,
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         en,
  input  logic [M-1:0] rem_in,
  input  logic [N-1:0] word_in,
  input  logic [M-1:0] div_in,
  input  logic [W-1:0] side_in,
  output logic [M-1:0] rem_out,
  output logic [N-1:0] word_out,
  output logic [M-1:0] div_out,
  output logic [W-1:0] side_out
);

  logic [M:0]   trial;
  logic         ge;
  logic [M-1:0] rem_nxt;
  logic [M-1:0] rem_r;
  logic [N-1:0] word_r;
  logic [M-1:0] div_r;
  logic [W-1:0] side_r;

  always_comb begin
    trial   = {rem_in, word_in[N-1]};
    ge      = trial >= {1'b0, div_in};
    rem_nxt = ge ? M'(trial - {1'b0, div_in}) : trial[M-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r  <= rem_nxt;
      word_r <= {word_in[N-2:0], ge};
      div_r  <= div_in;
      side_r <= side_in;
    end
  end

  assign rem_out  = rem_r;
  assign word_out = word_r;
  assign div_out  = div_r;
  assign side_out = side_r;

endmodule

// File: src/ubds_divider.sv
// Pipelined divider: a row of N division cells, one quotient bit each.
// Depends on ubds_div_cell.
module ubds_divider #(
  parameter int N = 33,
  parameter int M = 20,
  parameter int W = 16
) (
  input  logic         clk,
  input  logic         en,
  input  logic [N-1:0] dividend,
  input  logic [M-1:0] divisor,
  input  logic [W-1:0] side_in,
  output logic [N-1:0] quotient,
  output logic [W-1:0] side_out
);

  logic [M-1:0] rem_w  [0:N];
  logic [N-1:0] word_w [0:N];
  logic [M-1:0] div_w  [0:N];
  logic [W-1:0] side_w [0:N];

  assign rem_w[0]  = '0;
  assign word_w[0] = dividend;
  assign div_w[0]  = divisor;
  assign side_w[0] = side_in;

  for (genvar i = 0; i < N; i++) begin : g_cell
    ubds_div_cell #(.N(N), .M(M), .W(W)) u_cell (
      .clk      (clk),
      .en       (en),
      .rem_in   (rem_w[i]),
      .word_in  (word_w[i]),
      .div_in   (div_w[i]),
      .side_in  (side_w[i]),
      .rem_out  (rem_w[i+1]),
      .word_out (word_w[i+1]),
      .div_out  (div_w[i+1]),
      .side_out (side_w[i+1])
    );
  end

  assign quotient = word_w[N];
  assign side_out = side_w[N];

endmodule

// File: src/ubds_mode.sv
// Evaluates one oversampling mode: divisor, clamp flag and relative error.
// Depends on ubds_pkg and ubds_divider.
module ubds_mode #(
  parameter int SHIFT = 4
) (
  input  logic                         clk,
  input  logic                         en,
  input  logic [ubds_pkg::CLK_W-1:0]   clock_hz,
  input  logic [ubds_pkg::BAUD_W-1:0]  baud,
  output logic [ubds_pkg::PROD_W-1:0]  err,
  output logic [ubds_pkg::DIV_W-1:0]   dv,
  output logic                         clamp,
  output logic                         zero
);

  localparam int Q1_W   = ubds_pkg::Q1_W;
  localparam int D1_W   = ubds_pkg::D1_W;
  localparam int D2_W   = ubds_pkg::D2_W;
  localparam int BAUD_W = ubds_pkg::BAUD_W;
  localparam int DIV_W  = ubds_pkg::DIV_W;
  localparam int PROD_W = ubds_pkg::PROD_W;
  localparam int S2_W   = BAUD_W + DIV_W + 1;
  localparam int S3_W   = DIV_W + 2;

  // Divider one: raw = round(clock / (k * baud))
  logic [Q1_W-1:0]   n1;
  logic [D1_W-1:0]   d1;
  logic [Q1_W-1:0]   q1;
  logic [BAUD_W-1:0] baud1;

  assign n1 = Q1_W'(clock_hz) + (Q1_W'(baud) << (SHIFT - 1));
  assign d1 = D1_W'(baud) << SHIFT;

  ubds_divider #(.N(Q1_W), .M(D1_W), .W(BAUD_W)) u_div_raw (
    .clk (clk), .en (en), .dividend (n1), .divisor (d1),
    .side_in (baud), .quotient (q1), .side_out (baud1)
  );

  // Clamp the raw quotient into the divisor range
  logic [DIV_W-1:0]  dv_nxt;
  logic              clamp_nxt;
  logic [DIV_W-1:0]  dv_r;
  logic              clamp_r;
  logic [BAUD_W-1:0] baud_r;

  always_comb begin
    if (q1 == '0) begin
      dv_nxt    = '0;
      clamp_nxt = 1'b1;
    end else if (q1 > ubds_pkg::RAW_MAX) begin
      dv_nxt    = ubds_pkg::DIV_MAX;
      clamp_nxt = 1'b1;
    end else begin
      dv_nxt    = DIV_W'(q1 - Q1_W'(1));
      clamp_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv_r    <= dv_nxt;
      clamp_r <= clamp_nxt;
      baud_r  <= baud1;
    end
  end

  // Divider two: achieved = round(clock / (k * (dv + 1)))
  logic [DIV_W:0]    dv_inc;
  logic [Q1_W-1:0]   n2;
  logic [D2_W-1:0]   d2;
  logic [Q1_W-1:0]   q2;
  logic [S2_W-1:0]   side2;

  assign dv_inc = {1'b0, dv_r} + (DIV_W+1)'(1);
  assign n2     = Q1_W'(clock_hz) + (Q1_W'(dv_inc) << (SHIFT - 1));
  assign d2     = D2_W'(dv_inc) << SHIFT;

  ubds_divider #(.N(Q1_W), .M(D2_W), .W(S2_W)) u_div_ach (
    .clk (clk), .en (en), .dividend (n2), .divisor (d2),
    .side_in ({baud_r, dv_r, clamp_r}), .quotient (q2), .side_out (side2)
  );

  // Scale the achieved baud
  logic [PROD_W-1:0] prod_r;
  logic [BAUD_W-1:0] baud3_r;
  logic [DIV_W-1:0]  dv3_r;
  logic              clamp3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r   <= PROD_W'(q2[ubds_pkg::ACH_W-1:0]) * PROD_W'(ubds_pkg::ERR_SCALE);
      baud3_r  <= side2[S2_W-1 -: BAUD_W];
      dv3_r    <= side2[DIV_W:1];
      clamp3_r <= side2[0];
    end
  end

  // Divider three: rel = achieved * scale / baud
  logic [PROD_W-1:0] rel;
  logic [S3_W-1:0]   side3;

  ubds_divider #(.N(PROD_W), .M(BAUD_W), .W(S3_W)) u_div_rel (
    .clk (clk), .en (en), .dividend (prod_r), .divisor (baud3_r),
    .side_in ({baud3_r == '0, clamp3_r, dv3_r}), .quotient (rel), .side_out (side3)
  );

  // Absolute error against the scale
  logic [PROD_W-1:0] err_r;
  logic [DIV_W-1:0]  dv4_r;
  logic              clamp4_r;
  logic              zero4_r;

  always_ff @(posedge clk) begin
    if (en) begin
      err_r    <= (rel >= PROD_W'(ubds_pkg::ERR_SCALE)) ?
                  rel - PROD_W'(ubds_pkg::ERR_SCALE) : PROD_W'(ubds_pkg::ERR_SCALE) - rel;
      dv4_r    <= side3[DIV_W-1:0];
      clamp4_r <= side3[DIV_W];
      zero4_r  <= side3[DIV_W+1];
    end
  end

  assign err   = err_r;
  assign dv    = dv4_r;
  assign clamp = clamp4_r;
  assign zero  = zero4_r;

endmodule

// File: src/uart_baud_divisor_select.sv
// Top level of the UART baud divisor selector.
// Depends on ubds_pkg and ubds_mode.
//
// Give it a requested baud rate and it returns the divisor, the oversampling
// mode (16x or 8x double speed) and a status for the configured clock_hz. A new
// item is taken every cycle while in_stall is low: both modes run side by side
// through rows of restoring-division cells, one quotient bit per cell, three
// dividers deep (33 + 33 + 47 cells) with a clamp and a multiply stage between
// them and an error stage after them. The whole row advances together; when the
// output register holds an item that is stalled, the row holds and in_stall
// rises. clock_hz sits at byte address 0 of the APB port and must only be
// written while the block is idle.
module uart_baud_divisor_select (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [ubds_pkg::BAUD_W-1:0]   in_baud_rate,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [ubds_pkg::DIV_W-1:0]    out_divisor,
  output logic                          out_double_speed,
  output logic [1:0]                    out_status,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [ubds_pkg::ADDR_W-1:0]   paddr,
  input  logic [ubds_pkg::DATA_W-1:0]   pwdata,
  output logic [ubds_pkg::DATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int LAT    = ubds_pkg::LATENCY;
  localparam int PROD_W = ubds_pkg::PROD_W;
  localparam int DIV_W  = ubds_pkg::DIV_W;

  // Configuration register; bits below the word offset are ignored
  logic [ubds_pkg::CLK_W-1:0] clock_hz_r;
  logic                       reg_sel;

  assign reg_sel = paddr[2] == ubds_pkg::REG_CLOCK_HZ;
  assign pready  = 1'b1;
  assign prdata  = reg_sel ? clock_hz_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hz_r <= ubds_pkg::CLK_W'(12000000);
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      clock_hz_r <= pwdata;
    end
  end

  // Advance the whole row unless a finished item waits at a stalled output
  logic adv;
  assign adv      = !out_valid || !out_stall;
  assign in_stall = !adv;

  // Track which stages hold an item
  logic [LAT-1:0] vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[LAT-1];

  // Normal (16x) and double speed (8x) lanes
  logic [PROD_W-1:0] err_n, err_d;
  logic [DIV_W-1:0]  dv_n, dv_d;
  logic              clamp_n, clamp_d;
  logic              zero_n, zero_d;

  ubds_mode #(.SHIFT(4)) u_mode_norm (
    .clk (clk), .en (adv), .clock_hz (clock_hz_r), .baud (in_baud_rate),
    .err (err_n), .dv (dv_n), .clamp (clamp_n), .zero (zero_n)
  );

  ubds_mode #(.SHIFT(3)) u_mode_dbl (
    .clk (clk), .en (adv), .clock_hz (clock_hz_r), .baud (in_baud_rate),
    .err (err_d), .dv (dv_d), .clamp (clamp_d), .zero (zero_d)
  );

  // Pick the mode: normal only on a strictly smaller error, ties go to double speed
  logic [DIV_W-1:0]  divisor_nxt, divisor_r;
  logic              dbl_nxt, dbl_r;
  ubds_pkg::status_t status_nxt, status_r;

  always_comb begin
    if (zero_n || zero_d) begin
      divisor_nxt = '0;
      dbl_nxt     = 1'b0;
      status_nxt  = ubds_pkg::STATUS_ZERO;
    end else if (err_n < err_d) begin
      divisor_nxt = dv_n;
      dbl_nxt     = 1'b0;
      status_nxt  = clamp_n ? ubds_pkg::STATUS_CLAMPED : ubds_pkg::STATUS_OK;
    end else begin
      divisor_nxt = dv_d;
      dbl_nxt     = 1'b1;
      status_nxt  = clamp_d ? ubds_pkg::STATUS_CLAMPED : ubds_pkg::STATUS_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      divisor_r <= divisor_nxt;
      dbl_r     <= dbl_nxt;
      status_r  <= status_nxt;
    end
  end

  assign out_divisor      = divisor_r;
  assign out_double_speed = dbl_r;
  assign out_status       = status_r;

endmodule

// File: tb/uart_baud_divisor_select_test.sv
// Self-checking testbench for uart_baud_divisor_select: directed and random baud
// requests under several clock_hz settings, with a predictor of its own.
// Depends on ubds_pkg and the block's RTL only.
module uart_baud_divisor_select_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int CLK_W   = ubds_pkg::CLK_W;
  localparam int BAUD_W  = ubds_pkg::BAUD_W;
  localparam int DIV_W   = ubds_pkg::DIV_W;
  localparam int ADDR_W  = ubds_pkg::ADDR_W;
  localparam int DATA_W  = ubds_pkg::DATA_W;
  localparam int LATENCY = ubds_pkg::LATENCY;

  typedef struct packed {
    logic [DIV_W-1:0]  divisor;
    logic              double_speed;
    ubds_pkg::status_t status;
  } divisor_choice_t;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                in_valid = 1'b0;
  logic                in_stall;
  logic [BAUD_W-1:0]   in_baud_rate = '0;
  logic                out_valid;
  logic                out_stall = 1'b0;
  logic [DIV_W-1:0]    out_divisor;
  logic                out_double_speed;
  logic [1:0]          out_status;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [ADDR_W-1:0]   paddr = '0;
  logic [DATA_W-1:0]   pwdata = '0;
  logic [DATA_W-1:0]   prdata;
  logic                pready;

  // Predictor's own copy of the clock register
  logic [CLK_W-1:0]    model_clock_hz = 32'd12000000;
  divisor_choice_t     pending_choices[$];
  int                  fail_count = 0;
  int                  idle_cycles = 0;
  int                  max_gap = 11;
  int                  max_stall = 11;
  int                  stall_left = 0;

  uart_baud_divisor_select i_dut (
    .clk, .rst_n, .in_valid, .in_stall, .in_baud_rate,
    .out_valid, .out_stall, .out_divisor, .out_double_speed, .out_status,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #10 clk = ~clk;

  // Half-up rounded quotient: round up when the tenths digit exceeds four
  function automatic longint unsigned round_quotient(longint unsigned n,
                                                     longint unsigned d);
    longint unsigned q;
    longint unsigned r;
    q = n / d;
    r = n % d;
    if ((r * 10) / d > 4) q++;
    return q;
  endfunction

  // Divisor, clamp flag and relative error for one oversampling ratio
  function automatic void rate_for_oversampling(input longint unsigned baud,
                                                input longint unsigned k,
                                                output logic [DIV_W-1:0] div,
                                                output bit clamped,
                                                output longint unsigned err);
    longint unsigned raw;
    longint unsigned dv;
    longint unsigned achieved;
    longint unsigned rel;
    raw = round_quotient(model_clock_hz, k * baud);
    clamped = 1'b0;
    if (raw == 0) begin
      dv = 0;
      clamped = 1'b1;
    end else if (raw - 1 > ubds_pkg::DIV_MAX) begin
      dv = ubds_pkg::DIV_MAX;
      clamped = 1'b1;
    end else begin
      dv = raw - 1;
    end
    achieved = round_quotient(model_clock_hz, k * (dv + 1));
    rel = (achieved * 100000) / baud;
    err = (rel >= 100000) ? rel - 100000 : 100000 - rel;
    div = dv[DIV_W-1:0];
  endfunction

  function automatic divisor_choice_t choose_divisor(logic [BAUD_W-1:0] baud);
    divisor_choice_t  c;
    logic [DIV_W-1:0] div_normal, div_double;
    bit               clamp_normal, clamp_double;
    longint unsigned  err_normal, err_double;
    if (baud == 0) begin
      c.divisor = '0;
      c.double_speed = 1'b0;
      c.status = ubds_pkg::STATUS_ZERO;
      return c;
    end
    rate_for_oversampling(baud, 16, div_normal, clamp_normal, err_normal);
    rate_for_oversampling(baud, 8, div_double, clamp_double, err_double);
    // Normal mode only wins on a strictly smaller error; ties go to double speed
    if (err_normal < err_double) begin
      c.divisor = div_normal;
      c.double_speed = 1'b0;
      c.status = clamp_normal ? ubds_pkg::STATUS_CLAMPED : ubds_pkg::STATUS_OK;
    end else begin
      c.divisor = div_double;
      c.double_speed = 1'b1;
      c.status = clamp_double ? ubds_pkg::STATUS_CLAMPED : ubds_pkg::STATUS_OK;
    end
    return c;
  endfunction

  // Result side: after each item, hold stall for a drawn number of cycles
  always @(posedge clk) begin
    int draw;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      draw = $urandom_range(0, max_stall);
      if (draw > 0) begin
        out_stall <= 1'b1;
        stall_left <= draw - 1;
      end else begin
        out_stall <= 1'b0;
        stall_left <= 0;
      end
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Compare every accepted result with the oldest prediction
  always @(posedge clk) begin
    divisor_choice_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_choices.size() == 0) begin
        $display("%0t: unexpected result divisor=%0d ds=%0b status=%0d", $time,
                 out_divisor, out_double_speed, out_status);
        fail_count++;
      end else begin
        want = pending_choices.pop_front();
        if (out_divisor !== want.divisor) begin
          $display("%0t: divisor expected %0d actual %0d", $time, want.divisor,
                   out_divisor);
          fail_count++;
        end
        if (out_double_speed !== want.double_speed) begin
          $display("%0t: double_speed expected %0b actual %0b", $time,
                   want.double_speed, out_double_speed);
          fail_count++;
        end
        if (out_status !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   out_status);
          fail_count++;
        end
      end
    end
  end

  // Watchdog: count cycles in which nothing moves on any port
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  // Send one item after a drawn gap; keep valid high when there is no gap
  task automatic send_baud(logic [BAUD_W-1:0] baud);
    int gap;
    gap = $urandom_range(0, max_gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_baud_rate <= baud;
    do @(posedge clk); while (in_stall);
    pending_choices.push_back(choose_divisor(baud));
  endtask

  // Drain the pipe, then write clock_hz through a setup and an access cycle
  task automatic write_clock_hz(logic [CLK_W-1:0] value);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending_choices.size() == 0);
    repeat (LATENCY + 4) @(posedge clk);
    psel <= 1'b1;
    pwrite <= 1'b1;
    paddr <= {ubds_pkg::REG_CLOCK_HZ, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    model_clock_hz = value;
  endtask

  function automatic logic [BAUD_W-1:0] random_baud();
    int unsigned pick;
    logic [BAUD_W-1:0] common_rates[10] = '{300, 1200, 2400, 4800, 9600, 14400,
                                             19200, 38400, 57600, 31250};
    pick = $urandom_range(0, 9);
    if (pick < 4) return common_rates[$urandom_range(0, 9)];
    if (pick < 7) return BAUD_W'($urandom_range(0, 65535));
    return BAUD_W'($urandom_range(1, 600));
  endfunction

  // Field extremes, single-bit, alternating and split bit patterns and the usual UART rates
  task automatic test_directed_rates();
    logic [BAUD_W-1:0] rates[20] = '{0, 1, 2, 3, 65535, 16'h8000, 16'h5555,
                                     16'hAAAA, 16'h00FF, 16'hFF00, 300, 1200,
                                     2400, 4800, 9600, 19200, 38400, 57600,
                                     62500, 31250};
    foreach (rates[i]) send_baud(rates[i]);
  endtask

  // A one-hertz clock rounds every quotient to zero: drive the low clamp
  task automatic test_slowest_clock();
    write_clock_hz(32'd1);
    send_baud(16'd0);
    send_baud(16'd1);
    send_baud(16'd65535);
    send_baud(16'd9600);
  endtask

  // The widest clock overflows the divisor at low rates: drive the high clamp
  task automatic test_fastest_clock();
    write_clock_hz(32'hFFFF_FFFF);
    send_baud(16'd1);
    send_baud(16'd300);
    send_baud(16'd65535);
    send_baud(16'd0);
    send_baud(16'd9600);
  endtask

  task automatic test_random_rates(logic [CLK_W-1:0] clock_value, int count,
                                   int gap_limit, int stall_limit);
    write_clock_hz(clock_value);
    max_gap = gap_limit;
    max_stall = stall_limit;
    repeat (count) send_baud(random_baud());
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_rates();
    test_slowest_clock();
    test_fastest_clock();
    test_random_rates(32'd16000000, 150, 11, 11);
    test_random_rates(32'd7372800, 150, 0, 0);
    test_random_rates(32'd20000000, 150, 11, 11);
    test_random_rates(32'd12000000, 150, 3, 11);
    test_random_rates(32'd1, 100, 11, 0);
    test_random_rates(32'hFFFF_FFFF, 100, 11, 11);
    test_random_rates($urandom, 125, 11, 11);
    test_random_rates(32'($urandom_range(100000, 40000000)), 125, 0, 3);

    // Drain and let any stray result show up
    in_valid <= 1'b0;
    wait (pending_choices.size() == 0);
    repeat (LATENCY + 20) @(posedge clk);
    if (fail_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

// File: uart_baud_divisor_select.f
src/ubds_pkg.sv
src/ubds_div_cell.sv
src/ubds_divider.sv
src/ubds_mode.sv
src/uart_baud_divisor_select.sv
tb/uart_baud_divisor_select_test.sv
